### design/string_hash_bucket_index_defines.svh
// ----------------------------------------------------------------------------
// string_hash_bucket_index_defines.svh
// Assertion macros for the string hash bucket index block. The macros expect
// signals named clk and rst in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef STRING_HASH_BUCKET_INDEX_DEFINES_SVH
`define STRING_HASH_BUCKET_INDEX_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent holds in the same cycle as the antecedent.
`define SHBI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SHBI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SHBI_ASSERT_SAME(lbl, ante, cons, msg)
`define SHBI_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### design/shbi_pkg.sv
// ----------------------------------------------------------------------------
// shbi_pkg
// Shared types, codes and the CRC-32 byte step for the string hash block.
// ----------------------------------------------------------------------------
package shbi_pkg;

  localparam int HASH_W     = 64;
  localparam int CNT_W      = 17;
  localparam int IDX_W      = 16;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Hash mode codes
  localparam logic [MODE_W-1:0] MODE_FIRST = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ZERO  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LEN   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SUM   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_AVG   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ROR   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_ROL   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_CRC   = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HASH_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 1'b1;

  localparam logic [MODE_W-1:0] HASH_MODE_RST    = MODE_CRC;
  localparam logic [CNT_W-1:0]  BUCKET_COUNT_RST = 17'd1024;

  // Controller to datapath
  typedef struct packed {
    logic fold;      // fold a key byte into the running state
    logic start;     // terminator taken: load divider, clear string state
    logic reload;    // quotient ready: reload divider for the modulo
    logic out_load;  // move the finished result into the output register
  } shbi_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic term_byte;  // incoming byte is the terminator
    logic quot_path;  // sum/length mode with a non-empty string
    logic div_busy;   // divider is iterating
  } shbi_sts_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### design/shbi_div.sv
// ----------------------------------------------------------------------------
// shbi_div
// Restoring divider, one quotient bit per cycle over a 64-bit dividend.
// ----------------------------------------------------------------------------
module shbi_div #(
  parameter int DIV_W = 17
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [shbi_pkg::HASH_W-1:0] dividend,
  input  logic [DIV_W-1:0]            divisor,
  output logic                        busy,
  output logic [shbi_pkg::HASH_W-1:0] quotient,
  output logic [DIV_W-1:0]            remainder
);

  localparam int STEP_W = $clog2(shbi_pkg::HASH_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(shbi_pkg::HASH_W - 1);

  logic [shbi_pkg::HASH_W-1:0] quo;
  logic [DIV_W-1:0]            rem;
  logic [DIV_W-1:0]            dsr;
  logic [STEP_W-1:0]           step;
  logic [DIV_W:0]              shifted;
  logic [DIV_W:0]              trial;
  logic                        fits;

  always_comb begin
    shifted = {rem, quo[shbi_pkg::HASH_W-1]};
    trial   = shifted - {1'b0, dsr};
    fits    = !trial[DIV_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (load) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo <= {quo[shbi_pkg::HASH_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### design/shbi_dp.sv
// ----------------------------------------------------------------------------
// shbi_dp
// Datapath: configuration registers, per-string hash state, divider and
// result register.
// ----------------------------------------------------------------------------
module shbi_dp #(
  parameter int LENGTH_BITS = 16,
  parameter int BUCKET_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [shbi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shbi_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]                      data_byte,
  input  shbi_pkg::shbi_cmd_t             cmd,
  output shbi_pkg::shbi_sts_t             sts,
  output logic [shbi_pkg::HASH_W-1:0]     hash_value,
  output logic [shbi_pkg::IDX_W-1:0]      bucket_index
);

  localparam int SUM_W = LENGTH_BITS + 8;
  localparam int DIV_W = (LENGTH_BITS > shbi_pkg::CNT_W) ? LENGTH_BITS : shbi_pkg::CNT_W;
  localparam logic [32:0] CNT_MAX = 33'(1) << BUCKET_BITS;

  logic [shbi_pkg::MODE_W-1:0] hash_mode;
  logic [shbi_pkg::CNT_W-1:0]  bucket_count;
  logic [shbi_pkg::CNT_W-1:0]  eff_count;

  logic [31:0]                 crc_reg;
  logic [shbi_pkg::HASH_W-1:0] ror_reg;
  logic [shbi_pkg::HASH_W-1:0] rol_reg;
  logic [SUM_W-1:0]            byte_sum;
  logic [LENGTH_BITS-1:0]      char_count;
  logic [7:0]                  first_char;

  logic [SUM_W:0]              sum_add;
  logic [shbi_pkg::HASH_W-1:0] sel_hash;
  logic [shbi_pkg::HASH_W-1:0] hash_reg;

  logic                        div_load;
  logic [shbi_pkg::HASH_W-1:0] div_dividend;
  logic [DIV_W-1:0]            div_divisor;
  logic                        div_busy;
  logic [shbi_pkg::HASH_W-1:0] div_quo;
  logic [DIV_W-1:0]            div_rem;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mode    <= shbi_pkg::HASH_MODE_RST;
      bucket_count <= shbi_pkg::BUCKET_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        shbi_pkg::REG_HASH_MODE:    hash_mode    <= cfg_data[shbi_pkg::MODE_W-1:0];
        shbi_pkg::REG_BUCKET_COUNT: bucket_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero count means one bucket; clamp to the table size
  always_comb begin
    priority if (bucket_count == '0) begin
      eff_count = shbi_pkg::CNT_W'(1);
    end else if (33'(bucket_count) > CNT_MAX) begin
      eff_count = CNT_MAX[shbi_pkg::CNT_W-1:0];
    end else begin
      eff_count = bucket_count;
    end
  end

  assign sum_add = {1'b0, byte_sum} + (SUM_W + 1)'(data_byte);

  // Per-string state
  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      crc_reg    <= shbi_pkg::CRC_INIT;
      ror_reg    <= '0;
      rol_reg    <= '0;
      byte_sum   <= '0;
      char_count <= '0;
      first_char <= '0;
    end else if (cmd.fold) begin
      if (char_count == '0) begin
        first_char <= data_byte;
      end
      if (char_count != '1) begin
        char_count <= char_count + 1'b1;
      end
      byte_sum <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      ror_reg  <= {ror_reg[0], ror_reg[shbi_pkg::HASH_W-1:1]} ^ shbi_pkg::HASH_W'(data_byte);
      rol_reg  <= {rol_reg[shbi_pkg::HASH_W-2:0], rol_reg[shbi_pkg::HASH_W-1]}
                  ^ shbi_pkg::HASH_W'(data_byte);
      crc_reg  <= shbi_pkg::crc32_byte(crc_reg, data_byte);
    end
  end

  always_comb begin
    unique case (hash_mode)
      shbi_pkg::MODE_FIRST: sel_hash = shbi_pkg::HASH_W'(first_char);
      shbi_pkg::MODE_ZERO:  sel_hash = '0;
      shbi_pkg::MODE_LEN:   sel_hash = shbi_pkg::HASH_W'(char_count);
      shbi_pkg::MODE_SUM:   sel_hash = shbi_pkg::HASH_W'(byte_sum);
      shbi_pkg::MODE_AVG:   sel_hash = '0;
      shbi_pkg::MODE_ROR:   sel_hash = ror_reg;
      shbi_pkg::MODE_ROL:   sel_hash = rol_reg;
      shbi_pkg::MODE_CRC:   sel_hash = {32'b0, ~crc_reg};
      default:              sel_hash = '0;
    endcase
  end

  assign sts.term_byte = (data_byte == 8'd0);
  assign sts.quot_path = (hash_mode == shbi_pkg::MODE_AVG) && (char_count != '0);
  assign sts.div_busy  = div_busy;

  // Divider operand select
  always_comb begin
    div_load = cmd.start || cmd.reload;
    priority if (cmd.reload) begin
      div_dividend = div_quo;
      div_divisor  = DIV_W'(eff_count);
    end else if (sts.quot_path) begin
      div_dividend = shbi_pkg::HASH_W'(byte_sum);
      div_divisor  = DIV_W'(char_count);
    end else begin
      div_dividend = sel_hash;
      div_divisor  = DIV_W'(eff_count);
    end
  end

  shbi_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .load      (div_load),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Hash of the string in flight, then the output register
  always_ff @(posedge clk) begin
    if (div_load) begin
      hash_reg <= div_dividend;
    end
    if (cmd.out_load) begin
      hash_value   <= hash_reg;
      bucket_index <= div_rem[shbi_pkg::IDX_W-1:0];
    end
  end

endmodule

### design/shbi_ctrl.sv
// ----------------------------------------------------------------------------
// shbi_ctrl
// Controller: input/output handshakes and sequencing of the divider passes.
// ----------------------------------------------------------------------------
`include "string_hash_bucket_index_defines.svh"

module shbi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  shbi_pkg::shbi_sts_t sts,
  output shbi_pkg::shbi_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_QUOT = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd.fold     = accept && !sts.term_byte;
    cmd.start    = accept && sts.term_byte;
    cmd.reload   = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd.start) begin
          state_next = sts.quot_path ? ST_QUOT : ST_MOD;
        end
      end
      ST_QUOT: begin
        if (!sts.div_busy) begin
          cmd.reload = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!sts.div_busy && out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SHBI_ASSERT_SAME(a_idle_div_quiet, state == ST_IDLE, !sts.div_busy, "divider busy while idle")
  `SHBI_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "result overwritten")
  `SHBI_ASSERT_NEXT(a_term_leaves_idle, cmd.start, state != ST_IDLE, "terminator not processed")
  `SHBI_ASSERT_NEXT(a_reload_busy, cmd.reload, sts.div_busy, "modulo pass did not start")

endmodule

### design/string_hash_bucket_index.sv
// ----------------------------------------------------------------------------
// string_hash_bucket_index
// Streams a key one byte per beat and returns its hash and bucket index.
// ----------------------------------------------------------------------------
// A key arrives one byte per input beat; a zero byte ends it. Non-zero bytes
// fold into the running state of every hash mode as they are taken, so a key
// streams in at one byte per clock while the block is idle. The terminator
// produces one output beat with hash_value (the hash in the mode chosen by
// hash_mode) and bucket_index (hash_value modulo bucket_count, where a count
// of zero acts as one and a count above 2^BUCKET_BITS is clamped). The
// remainder comes from a shared restoring divider that retires one bit per
// cycle over the 64-bit hash, and the input stays stalled after the terminator
// while it divides and until the output register is loaded; in sum/length
// mode with a non-empty key the same divider first forms the quotient. A
// finished result sits in an output register, and the next key's bytes are
// taken while it waits; a following terminator is taken, and the input then
// holds until that register is free. hash_mode and bucket_count are written
// through cfg_write/cfg_index/cfg_data; the user must write them only while
// the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module string_hash_bucket_index #(
  parameter int LENGTH_BITS = 16,
  parameter int BUCKET_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port
  input  logic                            cfg_write,
  input  logic [shbi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shbi_pkg::CFG_DATA_W-1:0] cfg_data,
  // Key byte input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      data_byte,
  // Result output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [shbi_pkg::HASH_W-1:0]     hash_value,
  output logic [shbi_pkg::IDX_W-1:0]      bucket_index
);

  shbi_pkg::shbi_cmd_t cmd;
  shbi_pkg::shbi_sts_t sts;

  // Sequencing: handshakes, divider passes, output load
  shbi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hash state, divider and result register
  shbi_dp #(
    .LENGTH_BITS (LENGTH_BITS),
    .BUCKET_BITS (BUCKET_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .cmd          (cmd),
    .sts          (sts),
    .hash_value   (hash_value),
    .bucket_index (bucket_index)
  );

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: string hash bucket index
// Streams key strings byte by byte into the block and checks every result beat
// against a cycle-free predictor of all eight hash modes and the bucket
// modulo. The stimulus runs a directed pass over every mode and the bucket
// count extremes, then one long key, then random phases under bursty input
// and a stalling output.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_W        = 16;          // key length counter width
  localparam int SUM_W        = LEN_W + 8;   // byte sum width
  localparam int RANDOM_BYTES = 400;         // random stimulus, in input beats
  localparam int LONG_KEY     = 120;         // one key well past the usual length
  localparam int QUIET_LIMIT  = 3000;        // cycles without any beat before giving up
  localparam int TAIL_CYCLES  = 150;         // a little over the slowest terminator

  typedef struct packed {
    logic [shbi_pkg::HASH_W-1:0] hash;
    logic [shbi_pkg::IDX_W-1:0]  bucket;
  } bucket_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports
  // --------------------------------------------------------------------------
  logic                            clk;
  logic                            rst        = 1'b1;
  logic                            cfg_write  = 1'b0;
  logic [shbi_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [shbi_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
  logic                            in_valid   = 1'b0;
  logic                            in_ready;
  logic [7:0]                      data_byte  = '0;
  logic                            out_valid;
  logic                            out_ready  = 1'b0;
  logic [shbi_pkg::HASH_W-1:0]     hash_value;
  logic [shbi_pkg::IDX_W-1:0]      bucket_index;

  string_hash_bucket_index dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hash_value   (hash_value),
    .bucket_index (bucket_index)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: shadow registers plus the running per-key hash state
  // --------------------------------------------------------------------------
  logic [shbi_pkg::MODE_W-1:0] shadow_mode    = shbi_pkg::HASH_MODE_RST;
  logic [shbi_pkg::CNT_W-1:0]  shadow_buckets = shbi_pkg::BUCKET_COUNT_RST;

  logic [31:0]       crc_acc   = shbi_pkg::CRC_INIT;
  logic [63:0]       ror_acc   = '0;
  logic [63:0]       rol_acc   = '0;
  logic [SUM_W-1:0]  sum_acc   = '0;
  logic [LEN_W-1:0]  len_acc   = '0;
  logic [7:0]        first_acc = '0;

  logic [7:0]     pending_bytes[$];     // key bytes waiting for the driver
  bucket_result_t expected_hashes[$];   // predicted result beats, oldest first

  int        mismatch_count = 0;
  int        bytes_taken    = 0;
  int        keys_hashed    = 0;
  int        results_seen   = 0;
  int        settings_used  = 0;
  logic [7:0] modes_hit     = '0;
  int        quiet_cycles   = 0;
  bit        run_done       = 1'b0;

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Fold one accepted key byte into the running state; a zero byte closes the
  // key, queues the expected result and clears the state for the next key.
  task automatic fold_key_byte(input logic [7:0] b);
    logic [31:0]                 c;
    logic [SUM_W:0]              wide_sum;
    logic [shbi_pkg::HASH_W-1:0] h;
    logic [shbi_pkg::CNT_W-1:0]  divisor;
    bucket_result_t              r;
    if (b != 8'd0) begin
      if (len_acc == '0) first_acc = b;
      if (len_acc != '1) len_acc = len_acc + 1'b1;
      // saturate the sum instead of wrapping
      wide_sum = {1'b0, sum_acc} + (SUM_W + 1)'(b);
      sum_acc  = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
      ror_acc  = {ror_acc[0], ror_acc[63:1]} ^ {56'd0, b};
      rol_acc  = {rol_acc[62:0], rol_acc[63]} ^ {56'd0, b};
      // reflected CRC-32, one bit per step, LSB first
      c = crc_acc ^ {24'd0, b};
      for (int k = 0; k < 8; k++)
        c = c[0] ? ((c >> 1) ^ shbi_pkg::CRC_POLY) : (c >> 1);
      crc_acc = c;
    end else begin
      case (shadow_mode)
        shbi_pkg::MODE_FIRST: h = {56'd0, first_acc};
        shbi_pkg::MODE_ZERO:  h = '0;
        shbi_pkg::MODE_LEN:   h = {{(shbi_pkg::HASH_W-LEN_W){1'b0}}, len_acc};
        shbi_pkg::MODE_SUM:   h = {{(shbi_pkg::HASH_W-SUM_W){1'b0}}, sum_acc};
        shbi_pkg::MODE_AVG:   h = (len_acc == '0) ? '0 :
                                  shbi_pkg::HASH_W'(sum_acc) / shbi_pkg::HASH_W'(len_acc);
        shbi_pkg::MODE_ROR:   h = ror_acc;
        shbi_pkg::MODE_ROL:   h = rol_acc;
        default:              h = {32'd0, ~crc_acc};
      endcase
      // zero acts as one; anything past 2^16 is clamped to 2^16
      divisor = shadow_buckets;
      if (divisor == '0) divisor = shbi_pkg::CNT_W'(1);
      if (divisor > shbi_pkg::CNT_W'(1 << shbi_pkg::IDX_W))
        divisor = shbi_pkg::CNT_W'(1 << shbi_pkg::IDX_W);
      r.hash   = h;
      r.bucket = shbi_pkg::IDX_W'(h % shbi_pkg::HASH_W'(divisor));
      expected_hashes.push_back(r);
      modes_hit[shadow_mode] = 1'b1;
      keys_hashed++;
      crc_acc   = shbi_pkg::CRC_INIT;
      ror_acc   = '0;
      rol_acc   = '0;
      sum_acc   = '0;
      len_acc   = '0;
      first_acc = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of beats separated by random gaps
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : key_driver
    bit holding;
    if (rst) begin
      in_valid  <= 1'b0;
      data_byte <= '0;
    end else begin
      holding = in_valid;
      if (in_valid && in_ready) begin
        fold_key_byte(data_byte);
        bytes_taken++;
        holding = 1'b0;
      end
      // hold the beat until it is taken; otherwise idle or launch the next one
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          data_byte <= pending_bytes.pop_front();
          in_valid  <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            // some bursts are long enough to run with no idling at all
            burst_left = ($urandom_range(0, 9) < 2) ? $urandom_range(100, 400)
                                                   : $urandom_range(1, 12);
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4, 5: gap_left = $urandom_range(0, 3);
              6, 7, 8:          gap_left = $urandom_range(4, 20);
              default:          gap_left = $urandom_range(60, 150);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check result beats, stall the output, watch for a hang
  // --------------------------------------------------------------------------
  int rx_style = 0;
  int rx_style_left = 0;
  int rx_hold = 0;
  int rx_tick = 0;

  always @(posedge clk) begin : result_monitor
    bucket_result_t want;
    bit             next_ready;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_hashes.size() == 0) begin
          note_mismatch($sformatf("result beat with nothing expected: hash=%h bucket=%0d",
                                  hash_value, bucket_index));
        end else begin
          want = expected_hashes.pop_front();
          results_seen++;
          if (hash_value !== want.hash)
            note_mismatch($sformatf("key %0d hash_value: expected %h, got %h",
                                    results_seen, want.hash, hash_value));
          if (bucket_index !== want.bucket)
            note_mismatch($sformatf("key %0d bucket_index: expected %0d, got %0d",
                                    results_seen, want.bucket, bucket_index));
        end
      end

      // any beat or register write counts as progress
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
        quiet_cycles = 0;
      else
        quiet_cycles++;

      // switch the stall pattern now and then: always ready, coin flip, ready
      // when a tick counter hits a multiple of five, or ready with occasional long holds
      if (rx_style_left == 0) begin
        rx_style      = $urandom_range(0, 3);
        rx_style_left = $urandom_range(50, 400);
      end else begin
        rx_style_left--;
      end
      rx_tick++;
      case (rx_style)
        0: next_ready = 1'b1;
        1: next_ready = 1'($urandom_range(0, 1));
        2: next_ready = (rx_tick % 5) == 0;
        default: begin
          if (rx_hold > 0) begin
            rx_hold--;
            next_ready = 1'b0;
          end else begin
            next_ready = 1'b1;
            if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(5, 60);
          end
        end
      endcase
      out_ready <= next_ready;
    end
  end

  // Watchdog: end the run if nothing moves for too long
  initial begin
    do @(posedge clk); while (!run_done && quiet_cycles < QUIET_LIMIT);
    if (!run_done) begin
      $display("Watchdog: no beat for %0d cycles, %0d results still due",
               quiet_cycles, expected_hashes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Wait until the driver has nothing left and every result has come back.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || expected_hashes.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [shbi_pkg::CFG_IDX_W-1:0] idx,
                           input logic [shbi_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      shbi_pkg::REG_HASH_MODE:    shadow_mode    = val[shbi_pkg::MODE_W-1:0];
      shbi_pkg::REG_BUCKET_COUNT: shadow_buckets = val;
      default: ;
    endcase
  endtask

  // Drain, let the block settle, then write both registers in random order.
  // Upper bits of the mode write carry junk that the block must drop.
  task automatic reconfigure(input logic [shbi_pkg::MODE_W-1:0] mode,
                             input logic [shbi_pkg::CNT_W-1:0] buckets);
    logic [shbi_pkg::CFG_DATA_W-1:0] mode_word;
    wait_drained();
    repeat (4) @(posedge clk);
    mode_word = shbi_pkg::CFG_DATA_W'($urandom);
    mode_word[shbi_pkg::MODE_W-1:0] = mode;
    if ($urandom_range(0, 1)) begin
      write_reg(shbi_pkg::REG_HASH_MODE, mode_word);
      write_reg(shbi_pkg::REG_BUCKET_COUNT, shbi_pkg::CFG_DATA_W'(buckets));
    end else begin
      write_reg(shbi_pkg::REG_BUCKET_COUNT, shbi_pkg::CFG_DATA_W'(buckets));
      write_reg(shbi_pkg::REG_HASH_MODE, mode_word);
    end
    settings_used++;
  endtask

  function automatic logic [7:0] pick_key_byte();
    case ($urandom_range(0, 15))
      0:       return 8'hFF;
      1:       return 8'h01;
      2:       return 8'h80;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Mostly ordinary counts, with zero, one, the top and the clamped range
  function automatic logic [shbi_pkg::CNT_W-1:0] pick_buckets();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return shbi_pkg::CNT_W'(1);
      2:       return 17'd65536;
      3:       return shbi_pkg::CNT_W'($urandom_range(65537, 131071));
      4:       return '1;
      5, 6:    return shbi_pkg::CNT_W'($urandom_range(2, 16));
      default: return shbi_pkg::CNT_W'($urandom_range(1, 65536));
    endcase
  endfunction

  // Queue one random key plus its terminator; return the beats queued.
  function automatic int queue_random_key();
    int len;
    case ($urandom_range(0, 19))
      0, 1:    len = 0;
      18:      len = $urandom_range(25, 60);
      17, 16:  len = $urandom_range(9, 24);
      default: len = $urandom_range(1, 8);
    endcase
    for (int i = 0; i < len; i++) pending_bytes.push_back(pick_key_byte());
    pending_bytes.push_back(8'd0);
    return len + 1;
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [shbi_pkg::MODE_W-1:0] dir_modes[8];
    logic [shbi_pkg::CNT_W-1:0]  dir_buckets[8];
    int                          random_sent;
    int                          phase;
    int                          phase_goal;
    int                          phase_sent;
    bit                          paused;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: one key under the reset settings first
    pending_bytes.push_back(8'h80);
    pending_bytes.push_back(8'h00);

    // Directed: every mode on {FF, 01}, each with a different bucket extreme
    dir_modes   = '{shbi_pkg::MODE_FIRST, shbi_pkg::MODE_ZERO, shbi_pkg::MODE_LEN,
                    shbi_pkg::MODE_SUM, shbi_pkg::MODE_AVG, shbi_pkg::MODE_ROR,
                    shbi_pkg::MODE_ROL, shbi_pkg::MODE_CRC};
    dir_buckets = '{17'd1, 17'd0, 17'd65536, 17'h1FFFF,
                    17'd3, 17'd65535, 17'd7, 17'd1024};
    for (int m = 0; m < 8; m++) begin
      reconfigure(dir_modes[m], dir_buckets[m]);
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(8'h01);
      pending_bytes.push_back(8'h00);
      // empty key: divide-by-zero guard and the all-ones CRC init
      if (dir_modes[m] == shbi_pkg::MODE_AVG || dir_modes[m] == shbi_pkg::MODE_CRC)
        pending_bytes.push_back(8'h00);
    end

    // Long key, then a short key checks that the state was cleared afterwards
    reconfigure(shbi_pkg::MODE_AVG, 17'd1000);
    for (int i = 0; i < LONG_KEY; i++) pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'h02);
    pending_bytes.push_back(8'h04);
    pending_bytes.push_back(8'h00);

    // Random phases: sweep all modes first, then pick at random. Halfway
    // through each phase the sender holds until every result is back.
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_BYTES) begin
      reconfigure((phase < 8) ? shbi_pkg::MODE_W'(phase)
                              : shbi_pkg::MODE_W'($urandom_range(0, 7)),
                  pick_buckets());
      phase_goal = $urandom_range(40, 90);
      phase_sent = 0;
      paused     = 1'b0;
      while (phase_sent < phase_goal) begin
        phase_sent += queue_random_key();
        if (!paused && phase_sent >= phase_goal / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      random_sent += phase_sent;
      phase++;
    end

    // Drain, then give any stray result a chance to show up
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    run_done = 1'b1;
    if (expected_hashes.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_hashes.size()));

    $display("Run: %0d key bytes, %0d keys hashed over %0d register settings, modes hit %b",
             bytes_taken, keys_hashed, settings_used, modes_hit);
    $display("Run: %0d result beats checked, %0d mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/shbi_pkg.sv
design/shbi_div.sv
design/shbi_dp.sv
design/shbi_ctrl.sv
design/string_hash_bucket_index.sv
bench/testbench.sv
